// ===== design/rlcm_pkg.sv =====
// ----------------------------------------------------------------------------
// rlcm_pkg
// Shared constants, codes and controller/datapath interface types of the
// ring log commit manager.
// ----------------------------------------------------------------------------
package rlcm_pkg;

    localparam int SLOTS_MAX = 1024;
    localparam int PAGE_MAX  = 64;

    // Field widths fixed by the interface.
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;
    localparam int PAGE_W  = 10;
    localparam int PLEN_W  = 16;
    localparam int ROOM_W  = 7;
    localparam int RB_W    = 16;
    localparam int START_W = PAGE_W + ROOM_W;
    localparam int DCNT_W  = $clog2(SLOT_W);

    localparam logic [31:0] LOG_MAGIC   = 32'h4657_5244;
    localparam logic [15:0] LOG_VERSION = 16'd3;
    localparam logic [31:0] FNV_BASIS   = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME   = 32'd16777619;

    localparam logic [31:0] SEQ_RESET   = 32'd2;

    // Configuration register indexes.
    localparam logic REG_SLOT_CAPACITY = 1'b0;
    localparam logic REG_RECORD_BYTES  = 1'b1;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_PAGE   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_ENTRY  = 2'd2,
        KIND_EMPTY  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_DIV,
        ST_NORM_WB,
        ST_DISPATCH,
        ST_HASH,
        ST_COMMIT,
        ST_PAGE_CHK,
        ST_PAGE_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic div_init;
        logic div_step;
        logic norm_wb;
        logic update;
        logic hash_step;
        logic page_init;
        logic page_chk;
        logic load_commit;
        logic load_entry;
        logic load_empty;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        req_t req;
        logic oldest_lt_cap;
        logic div_last;
        logic hash_last;
        logic page_empty;
        logic entry_last;
        logic out_free;
    } status_t;

endpackage

// ===== design/rlcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlcm_ctrl
// Sequencing state machine: normalizes the log pointers, then runs the commit
// (pointer update plus byte-serial header checksum), page emission or neither.
// ----------------------------------------------------------------------------
module rlcm_ctrl
    import rlcm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_NORM;
                end
            end
            ST_NORM: begin
                // The remainder unit only runs when the oldest pointer is at
                // or beyond a reduced capacity.
                if (st.oldest_lt_cap) begin
                    cmd.norm_wb = 1'b1;
                    state_next  = ST_DISPATCH;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_last) begin
                    state_next = ST_NORM_WB;
                end
            end
            ST_NORM_WB: begin
                cmd.norm_wb = 1'b1;
                state_next  = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                unique case (st.req)
                    REQ_APPEND, REQ_CLEAR: begin
                        cmd.update = 1'b1;
                        state_next = ST_HASH;
                    end
                    REQ_PAGE: begin
                        cmd.page_init = 1'b1;
                        state_next    = ST_PAGE_CHK;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_HASH: begin
                cmd.hash_step = 1'b1;
                if (st.hash_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (st.out_free) begin
                    cmd.load_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_PAGE_CHK: begin
                cmd.page_chk = 1'b1;
                state_next   = ST_PAGE_OUT;
            end
            ST_PAGE_OUT: begin
                if (st.out_free) begin
                    if (st.page_empty) begin
                        cmd.load_empty = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        cmd.load_entry = 1'b1;
                        if (st.entry_last) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/rlcm_dp.sv =====
// ----------------------------------------------------------------------------
// rlcm_dp
// Datapath: log pointers and commit sequence, a bit-serial remainder unit,
// the byte-serial FNV-1a header checksum, page address generation and the
// result register.
// ----------------------------------------------------------------------------
module rlcm_dp
    import rlcm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output status_t               st,
    input  logic [COUNT_W-1:0]    slot_capacity,
    input  logic [RB_W-1:0]       record_bytes,
    input  logic [1:0]            s_req_type,
    input  logic [PAGE_W-1:0]     s_page_number,
    input  logic [PLEN_W-1:0]     s_page_length,
    input  logic [ROOM_W-1:0]     s_room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_kind,
    output logic [SLOT_W-1:0]     m_slot_index,
    output logic [31:0]           m_commit_seq,
    output logic                  m_header_slot,
    output logic [31:0]           m_header_checksum,
    output logic [COUNT_W-1:0]    m_record_count,
    output logic [SLOT_W-1:0]     m_oldest_slot,
    output logic                  m_last
);

    // Request registers.
    logic [1:0]         req_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [ROOM_W-1:0]  plen_reg;
    logic [ROOM_W-1:0]  room_reg;

    // Log state.
    logic [COUNT_W-1:0] held_reg,   held_next;
    logic [SLOT_W-1:0]  oldest_reg, oldest_next;
    logic [31:0]        seq_reg,    seq_next;
    logic [SLOT_W-1:0]  wslot_reg;

    // Remainder unit.
    logic [COUNT_W-1:0] rem_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [COUNT_W:0]   trial;

    // Checksum.
    logic [31:0]        hash_reg;
    logic [4:0]         hb_reg;
    logic [255:0]       header;
    logic [7:0]         hdr_byte;
    logic [31:0]        hash_mix;
    logic [31:0]        hash_prod;
    logic [31:0]        checksum;

    // Page walk.
    logic [START_W-1:0] start_reg;
    logic               empty_reg;
    logic [ROOM_W-1:0]  cnt_reg;
    logic [SLOT_W-1:0]  pos_reg;
    logic [COUNT_W-1:0] avail;
    logic [ROOM_W-1:0]  lim_plen;
    logic [ROOM_W-1:0]  limit;
    logic               page_empty;
    logic [COUNT_W-1:0] idx_sum;
    logic [SLOT_W-1:0]  idx;

    // Effective capacity and pointer arithmetic.
    logic [COUNT_W-1:0] cap;
    logic [COUNT_W-1:0] tail_sum;
    logic [SLOT_W-1:0]  tail_slot;
    logic [COUNT_W-1:0] oldest_inc;
    logic [ROOM_W-1:0]  plen_clamped;

    logic               out_valid_reg;
    logic               out_load;

    always_comb begin
        if (slot_capacity == '0) begin
            cap = COUNT_W'(1);
        end else if (slot_capacity > COUNT_W'(SLOTS_MAX)) begin
            cap = COUNT_W'(SLOTS_MAX);
        end else begin
            cap = slot_capacity;
        end
    end

    always_comb begin
        if (s_page_length == '0) begin
            plen_clamped = ROOM_W'(1);
        end else if (s_page_length > PLEN_W'(PAGE_MAX)) begin
            plen_clamped = ROOM_W'(PAGE_MAX);
        end else begin
            plen_clamped = s_page_length[ROOM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            req_reg  <= s_req_type;
            page_reg <= s_page_number;
            plen_reg <= plen_clamped;
            room_reg <= s_room;
        end
    end

    // Restoring remainder, one dividend bit per cycle, most significant first.
    assign trial = {rem_reg, oldest_reg[dcnt_reg]};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg  <= '0;
            dcnt_reg <= DCNT_W'(SLOT_W - 1);
        end else if (cmd.div_step) begin
            if (trial >= {1'b0, cap}) begin
                rem_reg <= COUNT_W'(trial - {1'b0, cap});
            end else begin
                rem_reg <= trial[COUNT_W-1:0];
            end
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
    end

    // Append: free tail while not full, else overwrite the oldest slot.
    assign tail_sum   = {1'b0, oldest_reg} + held_reg;
    assign tail_slot  = (tail_sum >= cap) ? SLOT_W'(tail_sum - cap) : tail_sum[SLOT_W-1:0];
    assign oldest_inc = {1'b0, oldest_reg} + COUNT_W'(1);

    always_comb begin
        held_next   = held_reg;
        oldest_next = oldest_reg;
        seq_next    = seq_reg;
        if (cmd.norm_wb) begin
            held_next   = (held_reg > cap) ? cap : held_reg;
            oldest_next = st.oldest_lt_cap ? oldest_reg : rem_reg[SLOT_W-1:0];
        end else if (cmd.update) begin
            seq_next = (seq_reg == '1) ? 32'd1 : seq_reg + 32'd1;
            if (req_t'(req_reg) == REQ_CLEAR) begin
                held_next   = '0;
                oldest_next = '0;
            end else if (held_reg < cap) begin
                held_next = held_reg + COUNT_W'(1);
            end else begin
                oldest_next = (oldest_inc == cap) ? '0 : oldest_inc[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg   <= '0;
            oldest_reg <= '0;
            seq_reg    <= SEQ_RESET;
        end else begin
            held_reg   <= held_next;
            oldest_reg <= oldest_next;
            seq_reg    <= seq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            if (req_t'(req_reg) == REQ_CLEAR) begin
                wslot_reg <= '0;
            end else if (held_reg < cap) begin
                wslot_reg <= tail_slot;
            end else begin
                wslot_reg <= oldest_reg;
            end
        end
    end

    // Header image, little-endian, checksum and reserved words zeroed.
    assign header = {64'h0, seq_reg, 22'h0, oldest_reg, 21'h0, held_reg,
                     21'h0, cap, record_bytes, LOG_VERSION, LOG_MAGIC};
    assign hdr_byte  = header[{hb_reg, 3'b000} +: 8];
    assign hash_mix  = hash_reg ^ {24'h0, hdr_byte};
    assign hash_prod = hash_mix * FNV_PRIME;
    assign checksum  = (hash_reg == '0) ? 32'd1 : hash_reg;

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            hash_reg <= FNV_BASIS;
            hb_reg   <= '0;
        end else if (cmd.hash_step) begin
            hash_reg <= hash_prod;
            hb_reg   <= hb_reg + 5'd1;
        end
    end

    // Page walk: newest record first, one slot per result.
    assign page_empty = (room_reg == '0) || (held_reg == '0) ||
                        (start_reg >= START_W'(held_reg));
    assign avail      = held_reg - start_reg[COUNT_W-1:0];
    assign lim_plen   = (avail < COUNT_W'(plen_reg)) ? avail[ROOM_W-1:0] : plen_reg;
    assign limit      = (lim_plen < room_reg) ? lim_plen : room_reg;
    assign idx_sum    = {1'b0, oldest_reg} + {1'b0, pos_reg};
    assign idx        = (idx_sum >= cap) ? SLOT_W'(idx_sum - cap) : idx_sum[SLOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.page_init) begin
            start_reg <= START_W'(page_reg) * START_W'(plen_reg);
        end
        if (cmd.page_chk) begin
            empty_reg <= page_empty;
            cnt_reg   <= limit;
            pos_reg   <= SLOT_W'(held_reg - COUNT_W'(1) - start_reg[COUNT_W-1:0]);
        end else if (cmd.load_entry) begin
            cnt_reg <= cnt_reg - ROOM_W'(1);
            pos_reg <= pos_reg - SLOT_W'(1);
        end
    end

    // Result register.
    assign out_load = cmd.load_commit || cmd.load_entry || cmd.load_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_record_count <= held_reg;
            m_oldest_slot  <= oldest_reg;
        end
        if (cmd.load_commit) begin
            m_kind            <= (req_t'(req_reg) == REQ_CLEAR) ? KIND_CLEAR : KIND_APPEND;
            m_slot_index      <= wslot_reg;
            m_commit_seq      <= seq_reg;
            m_header_slot     <= ~seq_reg[0];
            m_header_checksum <= checksum;
            m_last            <= 1'b1;
        end else if (cmd.load_entry) begin
            m_kind            <= KIND_ENTRY;
            m_slot_index      <= idx;
            m_commit_seq      <= '0;
            m_header_slot     <= 1'b0;
            m_header_checksum <= '0;
            m_last            <= (cnt_reg == ROOM_W'(1));
        end else if (cmd.load_empty) begin
            m_kind            <= KIND_EMPTY;
            m_slot_index      <= '0;
            m_commit_seq      <= '0;
            m_header_slot     <= 1'b0;
            m_header_checksum <= '0;
            m_last            <= 1'b1;
        end
    end

    assign m_valid = out_valid_reg;

    assign st.req           = req_t'(req_reg);
    assign st.oldest_lt_cap = ({1'b0, oldest_reg} < cap);
    assign st.div_last      = (dcnt_reg == '0);
    assign st.hash_last     = (hb_reg == '1);
    assign st.page_empty    = empty_reg;
    assign st.entry_last    = (cnt_reg == ROOM_W'(1));
    assign st.out_free      = !out_valid_reg || m_ready;

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !out_load)
        else $error("result register overwritten while waiting");

    // Page entries are only produced for a non-empty page.
    a_entry_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_entry |-> !empty_reg)
        else $error("page entry emitted for an empty page");

    // A committed header never carries a zero checksum.
    a_checksum_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_commit |=> (m_header_checksum != '0))
        else $error("zero header checksum committed");

    // The commit sequence never becomes zero.
    a_seq_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> (seq_reg != '0))
        else $error("commit sequence wrapped to zero");

endmodule

// ===== design/ring_log_commit_manager_top.sv =====
// ----------------------------------------------------------------------------
// ring_log_commit_manager_top
// Pointer and header-commit logic of a fixed-slot circular record log with an
// overwrite-oldest policy, with an APB register port for its configuration.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Handshake        | Contents
//   ---------+-----------+------------------+---------------------------------
//   s_*      | in        | s_valid/s_ready  | one request (append/clear/page)
//   m_*      | out       | m_valid/m_ready  | one result per commit or slot
//   APB      | in/out    | psel/penable     | slot_capacity (0x0), rec. (0x4)
//
// An append or clear registers its result once the byte-serial FNV-1a pass
// over the 32 header bytes (one multiply per byte) is done. A page read
// passes through the normalize, dispatch and page-check states, then gives
// one result per cycle while the output is not stalled, and an empty page
// gives a single result. When the oldest pointer is at or beyond a reduced
// capacity, a bit-serial remainder runs first. Reset is synchronous and
// active low, and no clearing pass is needed. A stalled result waits in the
// output register and the next request is taken once the last result of the
// current one is registered.
//
module ring_log_commit_manager_top
    import rlcm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic [PAGE_W-1:0]   s_page_number,
    input  logic [PLEN_W-1:0]   s_page_length,
    input  logic [ROOM_W-1:0]   s_room,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [SLOT_W-1:0]   m_slot_index,
    output logic [31:0]         m_commit_seq,
    output logic                m_header_slot,
    output logic [31:0]         m_header_checksum,
    output logic [COUNT_W-1:0]  m_record_count,
    output logic [SLOT_W-1:0]   m_oldest_slot,
    output logic                m_last
);

    logic [COUNT_W-1:0] slot_capacity_reg;
    logic [RB_W-1:0]    record_bytes_reg;
    logic               cfg_write;

    cmd_t    cmd;
    status_t st;

    // The port never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Registers sit at byte addresses 0x0 and 0x4; bit 2 picks the register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_capacity_reg <= COUNT_W'(SLOTS_MAX);
            record_bytes_reg  <= RB_W'(16);
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_SLOT_CAPACITY: slot_capacity_reg <= pwdata[COUNT_W-1:0];
                REG_RECORD_BYTES:  record_bytes_reg  <= pwdata[RB_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SLOT_CAPACITY: prdata = {{(32 - COUNT_W){1'b0}}, slot_capacity_reg};
            REG_RECORD_BYTES:  prdata = {{(32 - RB_W){1'b0}}, record_bytes_reg};
            default:           prdata = '0;
        endcase
    end

    // The controller sequences each request; the datapath holds the log state.
    rlcm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    rlcm_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .st                (st),
        .slot_capacity     (slot_capacity_reg),
        .record_bytes      (record_bytes_reg),
        .s_req_type        (s_req_type),
        .s_page_number     (s_page_number),
        .s_page_length     (s_page_length),
        .s_room            (s_room),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_slot_index      (m_slot_index),
        .m_commit_seq      (m_commit_seq),
        .m_header_slot     (m_header_slot),
        .m_header_checksum (m_header_checksum),
        .m_record_count    (m_record_count),
        .m_oldest_slot     (m_oldest_slot),
        .m_last            (m_last)
    );

endmodule
